// ----- rtl/ifs_fern_point_generator_macros.svh -----
// Assertion macros shared by the fern point generator RTL.
`ifndef IFS_FERN_POINT_GENERATOR_MACROS_SVH
`define IFS_FERN_POINT_GENERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IFSFERN_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IFSFERN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ifsfern_pkg.sv -----
// Package with the types and constants of the fern point generator.
package ifsfern_pkg;

	localparam int POINTS_PER_LEVEL = 1000;
	localparam int FRAC_BITS        = 16;
	localparam int RAND_BITS        = 16;

	// Field and register widths.
	localparam int PT_W       = FRAC_BITS + 8;
	localparam int LEVEL_W    = 6;
	localparam int DIM_W      = 13;
	localparam int CNT_W      = 16;
	localparam int PIX_W      = 12;
	localparam int COLOR_W    = 3;
	localparam int RAND_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Register indexes of the write port.
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	localparam logic [LEVEL_W-1:0] LEVEL_RST  = LEVEL_W'(10);
	localparam logic [DIM_W-1:0]   WIDTH_RST  = DIM_W'(1024);
	localparam logic [DIM_W-1:0]   HEIGHT_RST = DIM_W'(768);
	localparam logic [DIM_W-1:0]   DIM_MAX    = DIM_W'(4096);
	localparam logic [CNT_W-1:0]   LEVEL_MULT = CNT_W'(POINTS_PER_LEVEL);

	// Affine map codes.
	localparam logic [1:0] MAP_STEM  = 2'd0;
	localparam logic [1:0] MAP_MAIN  = 2'd1;
	localparam logic [1:0] MAP_LEFT  = 2'd2;
	localparam logic [1:0] MAP_RIGHT = 2'd3;

	// Map choice: rand * 100 against thresholds in units of 1/2^RAND_BITS.
	localparam int RS_W = RAND_BITS + 7;
	localparam logic [RS_W-1:0] R_HUNDRED = RS_W'(100);
	localparam logic [RS_W-1:0] TH_STEM   = RS_W'(1) << RAND_BITS;
	localparam logic [RS_W-1:0] TH_MAIN   = RS_W'(86) << RAND_BITS;
	localparam logic [RS_W-1:0] TH_LEFT   = RS_W'(93) << RAND_BITS;

	// Affine update in hundredths.
	localparam int COEF_W = 8;
	localparam int PROD_W = PT_W + COEF_W;
	localparam int SUM_W  = PROD_W;
	localparam logic signed [SUM_W-1:0] OFS_TALL  = SUM_W'(160) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] OFS_SHORT = SUM_W'(44) << FRAC_BITS;
	localparam logic signed [SUM_W-1:0] HALF_HUN  = SUM_W'(50);
	localparam logic signed [SUM_W-1:0] HUN_M1    = SUM_W'(99);

	// Division of a magnitude below 2^32 by 100 through a reciprocal.
	localparam int U_W         = 32;
	localparam int MG_W        = 64;
	localparam int MAGIC_SHIFT = 37;
	localparam int QM_W        = MG_W - MAGIC_SHIFT;
	localparam int QS_W        = QM_W + 1;
	localparam logic [U_W-1:0] MAGIC = 32'h51EB851F;

	localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
	localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};

	// Pixel mapping.
	localparam int A_W   = PT_W + 15;
	localparam int NUM_W = A_W + DIM_W + 1;
	localparam int SH_W  = NUM_W - FRAC_BITS - 1;
	localparam logic signed [15:0]    K_SCALE = 16'sd10000;
	localparam logic signed [A_W-1:0] X_OFS   = A_W'(21820) << FRAC_BITS;
	localparam logic signed [A_W-1:0] Y_OFS   = A_W'(99983) << FRAC_BITS;

	// Pixel divider: quotients of up to DIV_Q_W bits through a reciprocal
	// rounded up, exact for every dividend of DVD_W bits.
	localparam int     DIV_Q_W   = PIX_W;
	localparam int     DVR_W     = 17;
	localparam int     DVD_W     = DIV_Q_W + DVR_W;
	localparam int     RCP_W     = 32;
	localparam int     RCP_SHIFT = DVD_W + DVR_W;
	localparam int     RCP_P_W   = DVD_W + RCP_W;
	localparam longint X_DIV     = 48378;
	localparam longint Y_DIV     = 99983;
	localparam logic [RCP_W-1:0] X_RCP =
		RCP_W'(((longint'(1) << RCP_SHIFT) + X_DIV - 1) / X_DIV);
	localparam logic [RCP_W-1:0] Y_RCP =
		RCP_W'(((longint'(1) << RCP_SHIFT) + Y_DIV - 1) / Y_DIV);
	localparam logic [SH_W-1:0]  X_LIM = SH_W'(48378) << DIV_Q_W;
	localparam logic [SH_W-1:0]  Y_LIM = SH_W'(99983) << DIV_Q_W;

	// Colour bands.
	localparam logic [COLOR_W-1:0] COL_WHITE  = 3'd0;
	localparam logic [COLOR_W-1:0] COL_GREEN  = 3'd1;
	localparam logic [COLOR_W-1:0] COL_BLUE   = 3'd2;
	localparam logic [COLOR_W-1:0] COL_PURPLE = 3'd3;
	localparam logic [COLOR_W-1:0] COL_PINK   = 3'd4;
	localparam logic [COLOR_W-1:0] COL_RED    = 3'd5;

	typedef struct packed {
		logic              req_type;
		logic [RAND_W-1:0] rand_frac;
	} req_t;

	typedef struct packed {
		logic [PIX_W-1:0]   pixel_x;
		logic [PIX_W-1:0]   pixel_y;
		logic [COLOR_W-1:0] color;
		logic               last;
	} pt_t;

	typedef struct packed {
		logic start_load;
		logic capture_in;
		logic p1;
		logic p2;
		logic p3;
		logic set_point;
		logic div_start;
		logic div_sel_y;
		logic cap_px;
		logic cap_py;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic rem_zero;
		logic div_busy;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/ifsfern_div.sv -----
// Pixel divider: divides by one of the two fixed pixel-scale divisors through a reciprocal.
module ifsfern_div
	import ifsfern_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DVD_W-1:0]   dividend,
	input  logic               sel_y,
	output logic               busy,
	output logic               done,
	output logic [DIV_Q_W-1:0] quotient
);

	logic [DVD_W-1:0]   dvd_q;
	logic               sel_q;
	logic [RCP_P_W-1:0] prod_q;
	logic               busy_q;
	logic               done_q;
	logic [RCP_W-1:0]   rcp;

	assign rcp = sel_q ? Y_RCP : X_RCP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	// The reciprocal is rounded up; its error times any dividend stays below
	// 2^RCP_SHIFT, so the upper part of the product is the exact floor.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			sel_q <= sel_y;
		end
		if (busy_q) begin
			prod_q <= dvd_q * rcp;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = prod_q[RCP_SHIFT +: DIV_Q_W];

endmodule

// ----- rtl/ifsfern_dp.sv -----
// Datapath: registers, point state, affine update, pixel mapping and output word.
module ifsfern_dp
	import ifsfern_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  req_t                  req_word,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  pt_stall,
	output logic                  pt_valid,
	output pt_t                   pt_word
);

	typedef struct packed {
		logic [COEF_W-1:0] xa;
		logic [COEF_W-1:0] xb;
		logic [COEF_W-1:0] ya;
		logic [COEF_W-1:0] yb;
		logic [SUM_W-1:0]  ofs;
	} coef_t;

	function automatic logic [1:0] map_of(input logic [RAND_W-1:0] r);
		logic [RS_W-1:0] sc;
		sc = RS_W'(r[RAND_BITS-1:0]) * R_HUNDRED;
		priority if (sc < TH_STEM) return MAP_STEM;
		else if (sc < TH_MAIN) return MAP_MAIN;
		else if (sc < TH_LEFT) return MAP_LEFT;
		else return MAP_RIGHT;
	endfunction

	function automatic coef_t coef_of(input logic [1:0] m);
		coef_t c;
		unique case (m)
			MAP_STEM:  c = '{8'sd0,   8'sd0,   8'sd0,  8'sd16, '0};
			MAP_MAIN:  c = '{8'sd85,  8'sd4,   -8'sd4, 8'sd85, OFS_TALL};
			MAP_LEFT:  c = '{8'sd20,  -8'sd26, 8'sd23, 8'sd22, OFS_TALL};
			MAP_RIGHT: c = '{-8'sd15, 8'sd28,  8'sd26, 8'sd24, OFS_SHORT};
		endcase
		return c;
	endfunction

	function automatic logic [DIM_W-1:0] dim_of(input logic [DIM_W-1:0] d);
		priority if (d == '0) return DIM_W'(1);
		else if (d > DIM_MAX) return DIM_MAX;
		else return d;
	endfunction

	function automatic logic [COLOR_W-1:0] band_of(input logic [CNT_W-1:0] n);
		priority if (n < CNT_W'(5000)) return COL_WHITE;
		else if (n < CNT_W'(15000)) return COL_GREEN;
		else if (n < CNT_W'(25000)) return COL_BLUE;
		else if (n < CNT_W'(35000)) return COL_PURPLE;
		else if (n < CNT_W'(45000)) return COL_PINK;
		else if (n <= CNT_W'(50000)) return COL_RED;
		else return COL_WHITE;
	endfunction

	// Rounded quotient in magnitude and sign form, saturated to the point range.
	function automatic logic [PT_W-1:0] settle(input logic sgn, input logic [MG_W-1:0] mg);
		logic signed [QS_W-1:0] qs;
		logic [QM_W-1:0]        qm;
		qm = mg[MAGIC_SHIFT +: QM_W];
		qs = sgn ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
		priority if (qs > PT_MAX) return PT_MAX;
		else if (qs < PT_MIN) return PT_MIN;
		else return qs[PT_W-1:0];
	endfunction

	function automatic logic [PIX_W-1:0] pixel_of(
		input logic [NUM_W-1:0]   num,
		input logic [SH_W-1:0]    lim,
		input logic [DIV_Q_W-1:0] q,
		input logic [DIM_W-1:0]   dim
	);
		logic [PIX_W-1:0] dmax;
		dmax = PIX_W'(dim - 1'b1);
		priority if (num[NUM_W-1]) return '0;
		else if (num[NUM_W-2:FRAC_BITS] >= lim) return dmax;
		else if (q > dmax) return dmax;
		else return q;
	endfunction

	logic [LEVEL_W-1:0]        level_q;
	logic [DIM_W-1:0]          width_q;
	logic [DIM_W-1:0]          height_q;
	logic signed [PT_W-1:0]    point_x_q;
	logic signed [PT_W-1:0]    point_y_q;
	logic [CNT_W-1:0]          remaining_q;
	logic [1:0]                map_q;
	logic                      pt_valid_q;
	pt_t                       pt_word_q;
	logic [PIX_W-1:0]          pix_x_q;
	logic [PIX_W-1:0]          pix_y_q;

	logic signed [PROD_W-1:0]  pxa_s1, pxb_s1, pya_s1, pyb_s1;
	logic signed [SUM_W-1:0]   ofs_s1;
	logic signed [A_W-1:0]     ax_s1, ay_s1;
	logic signed [NUM_W-1:0]   num_x_s2, num_y_s2;
	logic [U_W-1:0]            ux_s2, uy_s2;
	logic                      sgx_s2, sgy_s2, sgx_s3, sgy_s3;
	logic [MG_W-1:0]           mgx_s3, mgy_s3;

	coef_t                     coef;
	logic signed [COEF_W-1:0]  c_xa, c_xb, c_ya, c_yb;
	logic [DIM_W-1:0]          w_dim, h_dim;
	logic signed [DIM_W:0]     w_s, h_s;
	logic signed [SUM_W-1:0]   v_x, v_y;
	logic [DVD_W-1:0]          div_dvd;
	logic                      div_busy, div_done;
	logic [DIV_Q_W-1:0]        div_q;

	assign coef  = coef_of(map_q);
	assign c_xa  = $signed(coef.xa);
	assign c_xb  = $signed(coef.xb);
	assign c_ya  = $signed(coef.ya);
	assign c_yb  = $signed(coef.yb);
	assign w_dim = dim_of(width_q);
	assign h_dim = dim_of(height_q);
	assign w_s   = $signed({1'b0, w_dim});
	assign h_s   = $signed({1'b0, h_dim});

	always_comb begin
		v_x = pxa_s1 + pxb_s1 + HALF_HUN;
		v_y = pya_s1 + pyb_s1 + $signed(ofs_s1) + HALF_HUN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q  <= LEVEL_RST;
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_LEVEL:  level_q  <= wr_data[LEVEL_W-1:0];
				REG_WIDTH:  width_q  <= wr_data[DIM_W-1:0];
				REG_HEIGHT: height_q <= wr_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_x_q   <= '0;
			point_y_q   <= '0;
			remaining_q <= '0;
			pt_valid_q  <= 1'b0;
		end else begin
			if (cmd.start_load) begin
				point_x_q   <= '0;
				point_y_q   <= '0;
				remaining_q <= CNT_W'(level_q * LEVEL_MULT);
			end
			if (cmd.set_point) begin
				point_x_q <= settle(sgx_s3, mgx_s3);
				point_y_q <= settle(sgy_s3, mgy_s3);
			end
			if (cmd.out_load) begin
				remaining_q <= remaining_q - 1'b1;
				pt_valid_q  <= 1'b1;
			end else if (!pt_stall) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_in) begin
			map_q <= map_of(req_word.rand_frac);
		end
		if (cmd.p1) begin
			pxa_s1 <= point_x_q * c_xa;
			pxb_s1 <= point_y_q * c_xb;
			pya_s1 <= point_x_q * c_ya;
			pyb_s1 <= point_y_q * c_yb;
			ofs_s1 <= $signed(coef.ofs);
			ax_s1  <= point_x_q * K_SCALE + X_OFS;
			ay_s1  <= Y_OFS - point_y_q * K_SCALE;
		end
		// Rounding of a negative value needs the ceiling of its magnitude.
		if (cmd.p2) begin
			num_x_s2 <= ax_s1 * w_s;
			num_y_s2 <= ay_s1 * h_s;
			sgx_s2   <= v_x[SUM_W-1];
			sgy_s2   <= v_y[SUM_W-1];
			ux_s2    <= v_x[SUM_W-1] ? U_W'(HUN_M1 - v_x) : U_W'(v_x);
			uy_s2    <= v_y[SUM_W-1] ? U_W'(HUN_M1 - v_y) : U_W'(v_y);
		end
		if (cmd.p3) begin
			mgx_s3 <= ux_s2 * MAGIC;
			mgy_s3 <= uy_s2 * MAGIC;
			sgx_s3 <= sgx_s2;
			sgy_s3 <= sgy_s2;
		end
		if (cmd.cap_px) begin
			pix_x_q <= pixel_of(num_x_s2, X_LIM, div_q, w_dim);
		end
		if (cmd.cap_py) begin
			pix_y_q <= pixel_of(num_y_s2, Y_LIM, div_q, h_dim);
		end
		if (cmd.out_load) begin
			pt_word_q.pixel_x <= pix_x_q;
			pt_word_q.pixel_y <= pix_y_q;
			pt_word_q.color   <= band_of(remaining_q);
			pt_word_q.last    <= remaining_q == CNT_W'(1);
		end
	end

	assign div_dvd = cmd.div_sel_y ? num_y_s2[FRAC_BITS +: DVD_W] : num_x_s2[FRAC_BITS +: DVD_W];

	ifsfern_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.sel_y    (cmd.div_sel_y),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_q)
	);

	assign sts.rem_zero = remaining_q == '0;
	assign sts.div_busy = div_busy;
	assign sts.div_done = div_done;
	assign sts.out_free = !pt_valid_q || !pt_stall;

	assign pt_valid = pt_valid_q;
	assign pt_word  = pt_word_q;

endmodule

// ----- rtl/ifsfern_ctrl.sv -----
// Controller state machine that sequences one point through the datapath.
module ifsfern_ctrl
	import ifsfern_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_type,
	input  sts_t sts,
	output logic req_stall,
	output cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_P1   = 3'd1;
	localparam logic [2:0] ST_P2   = 3'd2;
	localparam logic [2:0] ST_P3   = 3'd3;
	localparam logic [2:0] ST_SET  = 3'd4;
	localparam logic [2:0] ST_DX   = 3'd5;
	localparam logic [2:0] ST_DY   = 3'd6;
	localparam logic [2:0] ST_OUT  = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (!req_type) begin
						cmd.start_load = 1'b1;
					end else if (!sts.rem_zero) begin
						cmd.capture_in = 1'b1;
						state_d        = ST_P1;
					end
				end
			end
			ST_P1: begin
				cmd.p1  = 1'b1;
				state_d = ST_P2;
			end
			ST_P2: begin
				cmd.p2  = 1'b1;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.p3  = 1'b1;
				state_d = ST_SET;
			end
			// The pixel numerators are already registered, so the point can move now.
			ST_SET: begin
				cmd.set_point = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DX;
			end
			ST_DX: begin
				if (sts.div_done) begin
					cmd.cap_px    = 1'b1;
					cmd.div_start = 1'b1;
					cmd.div_sel_y = 1'b1;
					state_d       = ST_DY;
				end
			end
			ST_DY: begin
				if (sts.div_done) begin
					cmd.cap_py = 1'b1;
					state_d    = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_stall = state_q != ST_IDLE;

endmodule

// ----- rtl/ifs_fern_point_generator.sv -----
// Fern point generator top level. A start word puts the point at the origin
// and loads level * 1000 points; it gives no word. Each step word with points
// left gives one screen pixel with its colour band and a last flag, then moves
// the point by one of the four fern maps chosen by the random fraction. After
// acceptance a step word passes through affine products, rounding, pixel
// numerators and the point update, then through the shared reciprocal-multiply
// divider for the x and then the y pixel (multiply, then capture), and last
// loads the output register; the next word is taken only after that. A stalled
// output register holds the block in that last state until the word ahead is
// taken. A step with no points left is dropped. The output register holds a
// finished word while the next word is taken and worked on.
`include "ifs_fern_point_generator_macros.svh"

module ifs_fern_point_generator
	import ifsfern_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  req_t                  req_word,
	output logic                  pt_valid,
	input  logic                  pt_stall,
	output pt_t                   pt_word
);

	cmd_t cmd;
	sts_t sts;
	logic step_go;

	ifsfern_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_type  (req_word.req_type),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	ifsfern_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.req_word (req_word),
		.cmd      (cmd),
		.sts      (sts),
		.pt_stall (pt_stall),
		.pt_valid (pt_valid),
		.pt_word  (pt_word)
	);

	assign step_go = req_valid && !req_stall && req_word.req_type && !sts.rem_zero;

	`IFSFERN_ASSERT_SAME(a_div_start_idle, cmd.div_start, !sts.div_busy, "divider started while busy")
	`IFSFERN_ASSERT_SAME(a_out_load_free, cmd.out_load, sts.out_free, "output word overwritten")
	`IFSFERN_ASSERT_NEXT(a_step_blocks, step_go, req_stall, "step word did not block input")

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the fern point generator: predicted pixels vs. DUT output.
`timescale 1ns / 100ps

module tb_top;
	import ifsfern_pkg::*;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STEP  = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

	localparam int     SETTLE_CYCLES = 40;
	localparam int     LONG_HOLD     = 300;
	localparam int     LAST_STEPS    = 160;
	localparam longint Q_ONE         = longint'(1) << FRAC_BITS;
	localparam longint PT_HI         = (longint'(1) << (PT_W - 1)) - 1;
	localparam longint PT_LO         = -PT_HI - 1;

	logic                  clk;
	logic                  arst_n   = 1'b0;
	logic                  wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0]  wr_index = '0;
	logic [CFG_DATA_W-1:0] wr_data  = '0;
	logic                  req_valid = 1'b0;
	logic                  req_stall;
	req_t                  req_word  = '0;
	logic                  pt_valid;
	logic                  pt_stall  = 1'b0;
	pt_t                   pt_word;

	// Words waiting to be offered and pixels waiting to come out.
	req_t words_to_send[$];
	pt_t  pts_due[$];
	int   words_queued = 0;
	int   words_taken  = 0;
	int   err_cnt      = 0;

	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	bit   long_hold_ask  = 1'b0;
	bit   hold_done      = 1'b0;
	int   hold_left      = 0;

	// Shadow of the block's registers and walk state.
	logic [LEVEL_W-1:0]       lvl   = LEVEL_RST;
	logic [DIM_W-1:0]         scr_w = WIDTH_RST;
	logic [DIM_W-1:0]         scr_h = HEIGHT_RST;
	logic signed [PT_W-1:0]   fx    = '0;
	logic signed [PT_W-1:0]   fy    = '0;
	logic [CNT_W-1:0]         pts_left = '0;

	ifs_fern_point_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.pt_word   (pt_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint div_floor(longint v, longint d);
		longint q;
		q = v / d;
		if (v % d != 0 && v < 0)
			q--;
		return q;
	endfunction

	// Value in hundredths of an LSB, rounded half up and clamped to the point range.
	function automatic logic signed [PT_W-1:0] round_hundredths(longint v);
		longint q;
		q = div_floor(v + 50, 100);
		if (q > PT_HI)
			q = PT_HI;
		if (q < PT_LO)
			q = PT_LO;
		return PT_W'(q);
	endfunction

	function automatic longint eff_dim(logic [DIM_W-1:0] r);
		if (r == 0)
			return 1;
		if (r > DIM_MAX)
			return longint'(DIM_MAX);
		return longint'(r);
	endfunction

	function automatic logic [PIX_W-1:0] pix_clamp(longint v, longint dim);
		if (v < 0)
			return '0;
		if (v > dim - 1)
			return PIX_W'(dim - 1);
		return PIX_W'(v);
	endfunction

	function automatic logic [COLOR_W-1:0] color_band(logic [CNT_W-1:0] n);
		if (n >= 5000 && n < 15000)
			return COL_GREEN;
		if (n >= 15000 && n < 25000)
			return COL_BLUE;
		if (n >= 25000 && n < 35000)
			return COL_PURPLE;
		if (n >= 35000 && n < 45000)
			return COL_PINK;
		if (n >= 45000 && n <= 50000)
			return COL_RED;
		return COL_WHITE;
	endfunction

	// Advances the shadow walk by one accepted word and queues the pixel it yields.
	task automatic fern_predict(input req_t w);
		longint     x, y, wd, ht, px, py, full, scaled, nx, ny;
		logic [1:0] map;
		pt_t        p;
		if (w.req_type == REQ_START) begin
			fx = '0;
			fy = '0;
			pts_left = CNT_W'(longint'(lvl) * POINTS_PER_LEVEL);
		end else if (pts_left != 0) begin
			x  = longint'(fx);
			y  = longint'(fy);
			wd = eff_dim(scr_w);
			ht = eff_dim(scr_h);
			px = div_floor((x * 10000 + 21820 * Q_ONE) * wd, 48378 * Q_ONE);
			py = div_floor(ht * (99983 * Q_ONE - y * 10000), 99983 * Q_ONE);
			p.pixel_x = pix_clamp(px, wd);
			p.pixel_y = pix_clamp(py, ht);
			p.color   = color_band(pts_left);
			p.last    = (pts_left == 1);
			pts_due.push_back(p);

			full   = longint'(1) << RAND_BITS;
			scaled = (longint'(w.rand_frac) & (full - 1)) * 100;
			if (scaled < full)
				map = MAP_STEM;
			else if (scaled < 86 * full)
				map = MAP_MAIN;
			else if (scaled < 93 * full)
				map = MAP_LEFT;
			else
				map = MAP_RIGHT;
			case (map)
				MAP_STEM: begin
					nx = 0;
					ny = 16 * y;
				end
				MAP_MAIN: begin
					nx = 85 * x + 4 * y;
					ny = -4 * x + 85 * y + 160 * Q_ONE;
				end
				MAP_LEFT: begin
					nx = 20 * x - 26 * y;
					ny = 23 * x + 22 * y + 160 * Q_ONE;
				end
				default: begin
					nx = -15 * x + 28 * y;
					ny = 26 * x + 24 * y + 44 * Q_ONE;
				end
			endcase
			fx = round_hundredths(nx);
			fy = round_hundredths(ny);
			pts_left = pts_left - 1'b1;
		end
	endtask

	// Driver: offers queued words and predicts each one as it is accepted.
	always @(posedge clk or negedge arst_n) begin
		req_t nxt_word;
		logic nxt_valid;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_word  <= '0;
		end else begin
			nxt_valid = req_valid;
			nxt_word  = req_word;
			if (req_valid && !req_stall) begin
				fern_predict(req_word);
				words_taken++;
				nxt_valid = 1'b0;
			end
			if (!nxt_valid && words_to_send.size() != 0 &&
				$urandom_range(99, 0) >= send_idle_pct) begin
				nxt_word  = words_to_send.pop_front();
				nxt_valid = 1'b1;
			end
			req_valid <= nxt_valid;
			req_word  <= nxt_word;
		end
	end

	// Monitor: checks every accepted pixel word and drives the output stall.
	always @(posedge clk or negedge arst_n) begin
		pt_t want;
		if (!arst_n) begin
			pt_stall <= 1'b0;
		end else begin
			if (pt_valid && !pt_stall) begin
				if (pts_due.size() == 0) begin
					$error("pixel word with none expected: x %0d y %0d",
						pt_word.pixel_x, pt_word.pixel_y);
					err_cnt++;
				end else begin
					want = pts_due.pop_front();
					if (pt_word.pixel_x !== want.pixel_x) begin
						$error("pixel_x: expected %0d, got %0d", want.pixel_x, pt_word.pixel_x);
						err_cnt++;
					end
					if (pt_word.pixel_y !== want.pixel_y) begin
						$error("pixel_y: expected %0d, got %0d", want.pixel_y, pt_word.pixel_y);
						err_cnt++;
					end
					if (pt_word.color !== want.color) begin
						$error("color: expected %0d, got %0d", want.color, pt_word.color);
						err_cnt++;
					end
					if (pt_word.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, pt_word.last);
						err_cnt++;
					end
				end
			end
			// One long hold-off lets the block back up and stall its input.
			if (long_hold_ask && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pt_stall <= 1'b1;
			end else begin
				pt_stall <= ($urandom_range(99, 0) < recv_stall_pct);
			end
		end
	end

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		case (idx)
			REG_LEVEL:  lvl   = val[LEVEL_W-1:0];
			REG_WIDTH:  scr_w = val;
			REG_HEIGHT: scr_h = val;
			default: ;
		endcase
	endtask

	task automatic queue_word(input logic kind, input logic [RAND_W-1:0] frac);
		req_t w;
		w.req_type  = kind;
		w.rand_frac = frac;
		words_to_send.push_back(w);
		words_queued++;
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// Waits until every word is taken and every pixel is out, then lets the block settle.
	task automatic drain();
		while (words_taken != words_queued || pts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CFG_DATA_W-1:0] dim_pick(int k);
		case (k % 7)
			0: return 13'd0;
			1: return 13'd1;
			2: return 13'd4096;
			3: return 13'd4097;
			4: return 13'd8191;
			5: return 13'd1024;
			default: return CFG_DATA_W'($urandom_range(4096, 1));
		endcase
	endfunction

	// Random fraction, often right at a map threshold.
	function automatic logic [RAND_W-1:0] frac_pick();
		logic [RAND_W-1:0] edges[8] = '{16'd0, 16'd655, 16'd656, 16'd56360,
			16'd56361, 16'd60948, 16'd60949, 16'd65535};
		if ($urandom_range(9, 0) < 3)
			return edges[$urandom_range(7, 0)];
		return RAND_W'($urandom_range(65535, 0));
	endfunction

	initial begin
		int lvl_list[13] = '{0, 5, 14, 15, 24, 25, 34, 35, 44, 45, 50, 60, 63};
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset settings: a step before any start, every
		// map threshold from both sides, and a restart in the middle of a run.
		set_idling(0);
		queue_word(REQ_STEP, 16'hFFFF);
		queue_word(REQ_START, 16'h0000);
		queue_word(REQ_STEP, 16'd0);
		queue_word(REQ_STEP, 16'd655);
		queue_word(REQ_STEP, 16'd656);
		queue_word(REQ_STEP, 16'd56360);
		queue_word(REQ_STEP, 16'd56361);
		queue_word(REQ_STEP, 16'd60948);
		queue_word(REQ_STEP, 16'd60949);
		queue_word(REQ_STEP, 16'd65535);
		queue_word(REQ_STEP, 16'hAAAA);
		queue_word(REQ_STEP, 16'h5555);
		queue_word(REQ_START, 16'hFFFF);
		queue_word(REQ_STEP, 16'd65535);
		queue_word(REQ_STEP, 16'd12345);
		drain();

		// One setting per colour band edge, with odd screen sizes.
		for (int k = 0; k < 13; k++) begin
			cfg_write(REG_LEVEL, {7'($urandom), 6'(lvl_list[k])});
			cfg_write(REG_WIDTH, dim_pick(k));
			cfg_write(REG_HEIGHT, dim_pick(k + 3));
			if (k == 4)
				cfg_write(REG_SPARE, CFG_DATA_W'($urandom));
			@(posedge clk);
			wr_en <= 1'b0;
			set_idling(k);
			queue_word(REQ_START, RAND_W'($urandom));
			repeat (24) begin
				if ($urandom_range(19, 0) == 0)
					queue_word(REQ_START, RAND_W'($urandom));
				else
					queue_word(REQ_STEP, frac_pick());
			end
			drain();
		end

		// Smallest nonzero level with a long output hold-off near the start.
		cfg_write(REG_LEVEL, 13'd1);
		cfg_write(REG_WIDTH, CFG_DATA_W'($urandom_range(4096, 1)));
		cfg_write(REG_HEIGHT, CFG_DATA_W'($urandom_range(4096, 1)));
		@(posedge clk);
		wr_en <= 1'b0;
		set_idling(0);
		long_hold_ask = 1'b1;
		queue_word(REQ_START, 16'd0);
		repeat (LAST_STEPS)
			queue_word(REQ_STEP, frac_pick());
		drain();

		if (err_cnt == 0)
			$display("** ifs_fern_point_generator: PASSED **");
		else
			$display("** ifs_fern_point_generator: FAILED **");
		$finish;
	end

	initial begin
		#1000000;
		$display("** ifs_fern_point_generator: FAILED **");
		$finish;
	end

endmodule
